[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define IRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define IRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/irc_pkg.sv]
// Shared types, constants and helpers for the radix conversion block.
// Depends on nothing; imported by every module of the block.
package irc_pkg;

  localparam int NUM_W      = 64;
  localparam int BASE_W     = 8;
  localparam int DIG_W      = 6;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int DIG_SLOTS  = 64;
  localparam int PTR_W      = 6;
  localparam int CNT_W      = 7;
  localparam int BITS_PER_CYCLE = 8;
  localparam int STEP_W     = 3;
  localparam int CHAR_W     = 7;
  localparam logic [NUM_W-1:0] POS_MAX = {1'b0, {(NUM_W-1){1'b1}}};
  localparam logic [DIG_W-1:0] BASE_MIN = 6'd2;
  localparam logic [DIG_W-1:0] BASE_MAX = 6'd36;
  localparam logic [DIG_W-1:0] BASE_DEC = 6'd10;

  // Work handed from the front to the back: magnitude to print and its base.
  typedef struct packed {
    logic             is_null;
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [DIG_W-1:0] base;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < BASE_DEC) begin
      c = 7'd48 + {1'b0, d};
    end else begin
      c = 7'd55 + {1'b0, d};
    end
    return c;
  endfunction

endpackage

[rtl/core/irc_front.sv]
// Front end: takes requests, checks the bases, reads the decimal digits of
// the number in the source base and hands a print job to the queue. Uses irc_pkg.
module irc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          number,
  input  logic [7:0]           source_base,
  input  logic [7:0]           dst_base,
  output logic                 push,
  output irc_pkg::item_t       push_item,
  input  irc_pkg::fifo_stat_t  q_stat
);
  import irc_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_BCD   = 4'b0010,
    F_PARSE = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [NUM_W-1:0] num_r, bin_r, res_r, place_r;
  logic [BCD_W-1:0] bcd_r, bcd_adj;
  logic [DIG_W-1:0] cnt_r;
  logic [DIG_W-1:0] sbm_r;
  logic             sb_neg_r, null_r, conv_r, big_r, ovf_r;
  logic [BASE_W-1:0] db_r;

  logic [BASE_W-1:0] sbm_in, dbm_in;
  logic              sb_ok, db_ok, in_null;
  logic [3:0]        dgt;
  logic              d_bad, ovf_hit;
  logic [NUM_W+3:0]  prod_d;
  logic [NUM_W+4:0]  sum_d;
  logic [NUM_W+5:0]  prod_b;
  logic [NUM_W-1:0]  value, mag_out;
  logic [BASE_W-1:0] db_mag;
  logic [BCD_W-1:0]  bcd_shr;

  assign sbm_in = source_base[7] ? (8'd0 - source_base) : source_base;
  assign dbm_in = dst_base[7] ? (8'd0 - dst_base) : dst_base;
  assign sb_ok  = (sbm_in >= {2'b00, BASE_MIN}) && (sbm_in <= {2'b00, BASE_MAX});
  assign db_ok  = (dbm_in >= {2'b00, BASE_MIN}) && (dbm_in <= {2'b00, BASE_MAX});
  assign in_null = !sb_ok || !db_ok || (source_base[7] && !number[63]);

  assign in_ready = (state_r == F_IDLE);

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  assign dgt     = bcd_r[3:0];
  assign bcd_shr = {4'd0, bcd_r[BCD_W-1:4]};
  assign d_bad   = sb_neg_r || ({2'b00, dgt} >= sbm_r);
  assign prod_d  = {4'd0, place_r} * {{NUM_W{1'b0}}, dgt};
  assign sum_d   = {1'b0, prod_d} + {5'd0, res_r};
  assign prod_b  = {6'd0, place_r} * {{NUM_W{1'b0}}, sbm_r};
  assign ovf_hit = !d_bad && (dgt != 4'd0) &&
                   (big_r || (sum_d > {5'd0, POS_MAX}));

  always_comb begin
    if (null_r) begin
      value = '0;
    end else if (!conv_r) begin
      value = num_r;
    end else if (ovf_r) begin
      value = '1;
    end else if (num_r[63]) begin
      value = {NUM_W{1'b0}} - res_r;
    end else begin
      value = res_r;
    end
  end

  assign db_mag  = db_r[7] ? (8'd0 - db_r) : db_r;
  assign mag_out = (db_r[7] && value[63] && !null_r) ? ({NUM_W{1'b0}} - value) : value;

  assign push = (state_r == F_PUSH) && !q_stat.full;
  assign push_item.is_null = null_r;
  assign push_item.neg     = !null_r && db_r[7] && value[63];
  assign push_item.mag     = mag_out;
  assign push_item.base    = null_r ? BASE_DEC : db_mag[DIG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          if (in_null || (source_base == {2'b00, BASE_DEC})) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_BCD;
          end
        end
      end
      F_BCD: begin
        if (cnt_r == 6'd63) begin
          state_nxt = F_PARSE;
        end
      end
      F_PARSE: begin
        if (ovf_hit || (bcd_shr == '0)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          num_r    <= number;
          db_r     <= dst_base;
          null_r   <= in_null;
          conv_r   <= (source_base != {2'b00, BASE_DEC});
          sb_neg_r <= source_base[7];
          sbm_r    <= sbm_in[DIG_W-1:0];
          bin_r    <= number[63] ? ({NUM_W{1'b0}} - number) : number;
          bcd_r    <= '0;
          cnt_r    <= '0;
          ovf_r    <= 1'b0;
        end
      end
      F_BCD: begin
        // Shift-and-add-3 conversion of the magnitude, one bit per cycle.
        bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
        bin_r <= {bin_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        res_r   <= '0;
        place_r <= {{(NUM_W-1){1'b0}}, 1'b1};
        big_r   <= 1'b0;
      end
      F_PARSE: begin
        bcd_r <= bcd_shr;
        if (d_bad) begin
          // A digit outside the base, or a negative source base, restarts the reading.
          res_r   <= '0;
          place_r <= {{(NUM_W-1){1'b0}}, 1'b1};
          big_r   <= 1'b0;
        end else if (ovf_hit) begin
          ovf_r <= 1'b1;
        end else begin
          res_r <= sum_d[NUM_W-1:0];
          if (!big_r) begin
            if (prod_b > {6'd0, POS_MAX}) begin
              big_r <= 1'b1;
            end else begin
              place_r <= prod_b[NUM_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/irc_fifo.sv]
// Two-entry queue of print jobs between the front and the back end.
// Uses irc_pkg for the job type and the status struct.
module irc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  irc_pkg::item_t      push_item,
  input  logic                pop,
  output irc_pkg::item_t      pop_item,
  output irc_pkg::fifo_stat_t stat
);
  import irc_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/irc_back.sv]
// Back end: divides the magnitude by the base, eight quotient bits a cycle,
// keeps the digits in a small memory and sends them out most significant first.
// Uses irc_pkg.
module irc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  irc_pkg::item_t       pop_item,
  input  irc_pkg::fifo_stat_t  q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_null,
  output logic                 out_negative,
  output logic [6:0]           out_char,
  output logic                 out_last
);
  import irc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_RD   = 4'b0100,
    B_LD   = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DIG_W:0]    r_r, r_nxt;
  logic [DIG_W-1:0]  base_r;
  logic              neg_r, null_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [DIG_W-1:0]  dmem [DIG_SLOTS];
  logic [DIG_W-1:0]  rdata_r;
  logic              dig_we, rd_en, load_out;
  logic              ov_r, ol_r, on_r, oneg_r;
  logic [CHAR_W-1:0] oc_r;

  // Eight restoring-division steps with a narrow remainder.
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      r_nxt = {r_nxt[DIG_W-1:0], q_nxt[NUM_W-1]};
      if (r_nxt >= {1'b0, base_r}) begin
        r_nxt = r_nxt - {1'b0, base_r};
        q_nxt = {q_nxt[NUM_W-2:0], 1'b1};
      end else begin
        q_nxt = {q_nxt[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign pop      = (state_r == B_IDLE) && !q_stat.empty;
  assign dig_we   = (state_r == B_DIV) && (step_r == '1);
  assign rd_en    = (state_r == B_RD);
  assign load_out = (state_r == B_LD) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_stat.empty) state_nxt = B_DIV;
      B_DIV: begin
        if (dig_we && (q_nxt == '0)) begin
          state_nxt = B_RD;
        end
      end
      B_RD: state_nxt = B_LD;
      B_LD: begin
        if (load_out) begin
          state_nxt = (rd_ptr_r == '0) ? B_IDLE : B_RD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dmem[cnt_r[PTR_W-1:0]] <= r_nxt[DIG_W-1:0];
    end
    if (rd_en) begin
      rdata_r <= dmem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        q_r    <= pop_item.mag;
        base_r <= pop_item.base;
        neg_r  <= pop_item.neg;
        null_r <= pop_item.is_null;
        r_r    <= '0;
        step_r <= '0;
        cnt_r  <= '0;
      end
      B_DIV: begin
        q_r    <= q_nxt;
        step_r <= step_r + 3'd1;
        if (dig_we) begin
          r_r      <= '0;
          cnt_r    <= cnt_r + 7'd1;
          rd_ptr_r <= cnt_r[PTR_W-1:0];
        end else begin
          r_r <= r_nxt;
        end
      end
      B_LD: begin
        if (load_out) begin
          rd_ptr_r <= rd_ptr_r - 6'd1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      oc_r   <= digit_char(rdata_r);
      ol_r   <= (rd_ptr_r == '0);
      on_r   <= null_r;
      oneg_r <= neg_r;
    end
  end

  assign out_valid    = ov_r;
  assign out_is_null  = on_r;
  assign out_negative = oneg_r;
  assign out_char     = oc_r;
  assign out_last     = ol_r;

endmodule

[rtl/core/integer_radix_conversion.sv]
// Integer radix conversion, bases 2 to 36. A request carries a signed 64-bit
// number and signed source and destination bases; the block answers with one
// result per output digit, most significant first, or one null result for a
// bad base or for a non-negative number with a negative source base. For a
// decimal source or a null request the front end hands the job straight on;
// otherwise it runs 64 bit-serial BCD steps, reads the decimal digits, then
// hands the job on. The back end runs its divider over the whole quotient for
// each output digit, then sends each digit through a read and a load state; a
// binary answer has up to 64 digits. A two-entry queue lets the front end
// read the next request while the back end is still printing.
// Depends on irc_pkg, irc_front, irc_fifo, irc_back and assert_macros.svh.
`include "assert_macros.svh"

module integer_radix_conversion (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // number[63:0], source_base[71:64], dest_base[79:72]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // digit_char[6:0], zero[7]
  output logic [1:0]  out_tuser,  // is_null[0], negative[1]
  output logic        out_tlast
);
  import irc_pkg::*;

  logic       push, pop;
  item_t      push_item, pop_item;
  fifo_stat_t q_stat;
  logic [6:0] out_char;

  irc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .number     (in_tdata[63:0]),
    .source_base(in_tdata[71:64]),
    .dst_base   (in_tdata[79:72]),
    .push       (push),
    .push_item  (push_item),
    .q_stat     (q_stat)
  );

  irc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (pop_item),
    .stat     (q_stat)
  );

  irc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_item    (pop_item),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_is_null (out_tuser[0]),
    .out_negative(out_tuser[1]),
    .out_char    (out_char),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  `IRC_ASSERT_IMP(a_null_alone, out_tvalid && out_tuser[0], out_tlast && (out_tdata == 8'h30) && !out_tuser[1], "null result must be a lone zero")
  `IRC_ASSERT_IMP(a_char_set, out_tvalid, ((out_tdata >= 8'h30) && (out_tdata <= 8'h39)) || ((out_tdata >= 8'h41) && (out_tdata <= 8'h5A)), "digit character out of set")
  `IRC_ASSERT_IMP(a_no_overflow, push, !q_stat.full, "job queue written while full")
  `IRC_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

endmodule
